@@ rtl/track_ref_to_helix_params_macros.svh @@
// Assertion macros for the checker file of the track point converter.
`ifndef TRACK_REF_TO_HELIX_PARAMS_MACROS_SVH
`define TRACK_REF_TO_HELIX_PARAMS_MACROS_SVH

// Check a consequence in the same cycle, off during reset.
`define TR2H_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("track point converter check failed");

// Check a consequence in the next cycle, off during reset.
`define TR2H_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("track point converter check failed");

// Check a consequence in the next cycle, also across reset.
`define TR2H_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("track point converter check failed");

`endif

@@ rtl/tr2h_pkg.sv @@
// Shared constants, types and helpers of the track point converter.
package tr2h_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam int SQRT_STEPS   = 30;
   localparam int RAD_W        = 2 * SQRT_STEPS;
   localparam int REM_W        = SQRT_STEPS + 2;
   localparam int DIV_BITS     = 24;
   localparam int DIV_LAT      = DIV_BITS + 1;
   localparam int NUM_W        = 74;
   localparam int DEN_W        = 60;

   localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   localparam logic [23:0] CAP_Q15 = 24'h007FFF;
   localparam logic [23:0] CAP_Q16 = 24'h7FFFFF;

   // Side data carried beside the square root units.
   typedef struct packed {
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic [19:0]        pos_z;
      logic               neg_q;
      logic               pt0;
      logic               r0;
      logic               c_neg;
      logic [38:0]        c_mag;
      logic               py_neg;
      logic [19:0]        py_mag;
      logic               pz_neg;
      logic [19:0]        pz_mag;
   } side_a_type;

   // Side data carried beside the dividers.
   typedef struct packed {
      logic [19:0] pos_z;
      logic [19:0] radius;
      logic [15:0] angle;
      logic        neg_q;
      logic        pt0;
      logic        sin_neg;
      logic        pz_neg;
   } side_b_type;

   // Clamp a quotient to the positive or negative limit and apply the sign.
   function automatic logic [23:0] sat_signed(logic [23:0] q, logic ovf, logic neg,
                                              logic [23:0] cap_pos);
      logic [23:0] cap;
      logic [23:0] qs;
      cap = neg ? cap_pos + 24'd1 : cap_pos;
      qs  = (ovf || q > cap) ? cap : q;
      return neg ? 24'(-qs) : qs;
   endfunction

endpackage

@@ rtl/tr2h_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module tr2h_sqrt
   import tr2h_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic [RAD_W-1:0]      radicand,
   output logic [SQRT_STEPS-1:0] root_out
);

   logic [RAD_W-1:0]      rad_ff  [0:SQRT_STEPS-1];
   logic [REM_W-1:0]      rem_ff  [0:SQRT_STEPS-1];
   logic [SQRT_STEPS-1:0] root_ff [0:SQRT_STEPS-1];
   logic [RAD_W-1:0]      rad_in  [0:SQRT_STEPS-1];
   logic [REM_W-1:0]      rem_in  [0:SQRT_STEPS-1];
   logic [SQRT_STEPS-1:0] root_in [0:SQRT_STEPS-1];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [RAD_W-1:0]      rad_src;
      logic [REM_W-1:0]      rem_src;
      logic [SQRT_STEPS-1:0] root_src;
      logic [REM_W+1:0]      rem_ext;
      logic [REM_W+1:0]      trial;
      logic                  ge;

      if (k == 0) begin : g_first
         assign rad_src  = radicand;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      // Bring down two radicand bits and try the next root bit
      assign rem_ext    = {rem_src, rad_src[RAD_W-1 -: 2]};
      assign trial      = (REM_W+2)'({root_src, 2'b01});
      assign ge         = rem_ext >= trial;
      assign rem_in[k]  = ge ? REM_W'(rem_ext - trial) : REM_W'(rem_ext);
      assign root_in[k] = {root_src[SQRT_STEPS-2:0], ge};
      assign rad_in[k]  = {rad_src[RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign root_out = root_ff[SQRT_STEPS-1];

endmodule

@@ rtl/tr2h_cordic.sv @@
// Pipelined vectoring CORDIC giving atan2(y,x) in units of pi/32768.
module tr2h_cordic
   import tr2h_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [19:0] pos_x,
   input  logic signed [19:0] pos_y,
   output logic [15:0]        angle
);

   logic signed [31:0] cx_ff [0:CORDIC_STEPS];
   logic signed [31:0] cy_ff [0:CORDIC_STEPS];
   logic [31:0]        cz_ff [0:CORDIC_STEPS];
   logic               null_ff [0:CORDIC_STEPS];
   logic signed [31:0] cx_in [1:CORDIC_STEPS];
   logic signed [31:0] cy_in [1:CORDIC_STEPS];
   logic [31:0]        cz_in [1:CORDIC_STEPS];
   logic signed [31:0] x_scaled;
   logic signed [31:0] y_scaled;
   logic               x_neg;
   logic [31:0]        z_round;
   logic [15:0]        angle_ff;

   // Scale up and fold the left half plane onto the right
   assign x_scaled = {{4{pos_x[19]}}, pos_x, 8'h00};
   assign y_scaled = {{4{pos_y[19]}}, pos_y, 8'h00};
   assign x_neg    = pos_x[19];

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]   <= x_neg ? -x_scaled : x_scaled;
         cy_ff[0]   <= x_neg ? -y_scaled : y_scaled;
         cz_ff[0]   <= x_neg ? 32'h80000000 : 32'h00000000;
         null_ff[0] <= (pos_x == '0) && (pos_y == '0);
      end
   end

   // Rotate toward the x axis, one micro-rotation per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [31:0] xs;
      logic signed [31:0] ys;
      logic               up;

      assign xs = cx_ff[i] >>> i;
      assign ys = cy_ff[i] >>> i;
      assign up = cy_ff[i] > 32'sd0;
      assign cx_in[i+1] = up ? cx_ff[i] + ys : cx_ff[i] - ys;
      assign cy_in[i+1] = up ? cy_ff[i] - xs : cy_ff[i] + xs;
      assign cz_in[i+1] = up ? cz_ff[i] + ATAN_TAB[i] : cz_ff[i] - ATAN_TAB[i];

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i+1]   <= cx_in[i+1];
            cy_ff[i+1]   <= cy_in[i+1];
            cz_ff[i+1]   <= cz_in[i+1];
            null_ff[i+1] <= null_ff[i];
         end
      end
   end

   // Round the angle word to 16 bits; a point at the origin gives zero
   assign z_round = cz_ff[CORDIC_STEPS] + 32'h00008000;

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= null_ff[CORDIC_STEPS] ? 16'h0000 : z_round[31:16];
      end
   end

   assign angle = angle_ff;

endmodule

@@ rtl/tr2h_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module tr2h_div
   import tr2h_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [NUM_W-1:0]    num,
   input  logic [DEN_W-1:0]    den,
   output logic [DIV_BITS-1:0] quot,
   output logic                ovf
);

   logic [NUM_W-1:0]    rem_ff [0:DIV_BITS];
   logic [DEN_W-1:0]    den_ff [0:DIV_BITS];
   logic [DIV_BITS-1:0] q_ff   [0:DIV_BITS];
   logic                ovf_ff [0:DIV_BITS];
   logic [NUM_W-1:0]    rem_in [1:DIV_BITS];
   logic [DIV_BITS-1:0] q_in   [1:DIV_BITS];

   // Flag a quotient that does not fit in the quotient width
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= DEN_W'(num[NUM_W-1:DIV_BITS]) >= den;
      end
   end

   // Resolve quotient bits from the top down
   for (genvar s = 1; s <= DIV_BITS; s++) begin : g_bit
      localparam int K = DIV_BITS - s;
      logic [NUM_W-1:0] den_ext;
      logic             ge;

      assign den_ext   = NUM_W'(den_ff[s-1]);
      assign ge        = (rem_ff[s-1] >> K) >= den_ext;
      assign rem_in[s] = ge ? rem_ff[s-1] - (den_ext << K) : rem_ff[s-1];
      assign q_in[s]   = {q_ff[s-1][DIV_BITS-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_ff[s-1];
            q_ff[s]   <= q_in[s];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign quot = q_ff[DIV_BITS];
   assign ovf  = ovf_ff[DIV_BITS];

endmodule

@@ rtl/track_ref_to_helix_params.sv @@
// Top level: track point to local helix parameters, fully pipelined.
//
//   channel  dir  tdata (low bit up)                              tuser
//   req      in   pos_x pos_y pos_z mom_x mom_y mom_z (120 bits)  negative_charge
//   rsp      out  radius_xy frame_angle local_z sine_phi           pt_zero
//                 dip_tangent inv_pt_signed (120 bits)
//
// One request enters per cycle unless a held result stalls the pipeline.
// The pipeline holds the 30-stage square root, the multiply stage and the
// 25-stage dividers, all running in lockstep on one advance enable.
// Reset (synchronous) clears the valid bits only; no warm-up pass is needed.
// A held result stalls the whole pipeline; nothing is dropped or repeated.
module track_ref_to_helix_params
   import tr2h_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,  // pos_x, pos_y, pos_z, mom_x, mom_y, mom_z
   input  logic [0:0]   req_tuser,  // negative_charge
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,  // radius_xy, frame_angle, local_z, sine_phi,
                                    // dip_tangent, inv_pt_signed
   output logic [0:0]   rsp_tuser   // pt_zero
);

   localparam int CORDIC_TAP = SQRT_STEPS - CORDIC_LAT;
   localparam int DEPTH      = 3 + SQRT_STEPS + 1 + DIV_LAT + 1;

   logic             en;
   logic [DEPTH-1:0] v_ff;

   logic signed [19:0] x_ff, y_ff, z_ff, px_ff, py_ff, pz_ff;
   logic               negq_ff;
   logic signed [39:0] xx_ff, yy_ff, pxx_ff, pyy_ff, xpy_ff, ypx_ff;
   logic signed [19:0] x1_ff, y1_ff, z1_ff, py1_ff, pz1_ff;
   logic               negq1_ff;
   logic [39:0]        r2_ff, p2_ff;
   logic [39:0]        r2_in, p2_in;
   logic signed [40:0] c_in;
   side_a_type         a_in;
   side_a_type         da_ff [0:SQRT_STEPS];
   logic [SQRT_STEPS-1:0] rf, pf;
   logic [15:0]        angle;
   side_a_type         a_end;
   logic [DEN_W-1:0]   dsin_ff, pf_ff;
   logic [NUM_W-1:0]   nsin_ff, ndip_ff;
   side_b_type         b_in;
   side_b_type         db_ff [0:DIV_LAT];
   logic [DIV_BITS-1:0] q_sin, q_dip, q_inv;
   logic               o_sin, o_dip, o_inv;
   side_b_type         b_end;
   logic [23:0]        sin_in, dip_in, inv_in;
   logic [119:0]       data_ff;
   logic               pt0_ff;

   // Advance when the output slot is free or being taken
   assign en         = !v_ff[DEPTH-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= req_tdata[19:0];
         y_ff    <= req_tdata[39:20];
         z_ff    <= req_tdata[59:40];
         px_ff   <= req_tdata[79:60];
         py_ff   <= req_tdata[99:80];
         pz_ff   <= req_tdata[119:100];
         negq_ff <= req_tuser[0];
      end
   end

   // Squares and cross products
   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff    <= x_ff * x_ff;
         yy_ff    <= y_ff * y_ff;
         pxx_ff   <= px_ff * px_ff;
         pyy_ff   <= py_ff * py_ff;
         xpy_ff   <= x_ff * py_ff;
         ypx_ff   <= y_ff * px_ff;
         x1_ff    <= x_ff;
         y1_ff    <= y_ff;
         z1_ff    <= z_ff;
         py1_ff   <= py_ff;
         pz1_ff   <= pz_ff;
         negq1_ff <= negq_ff;
      end
   end

   // Sums, magnitudes and signs
   assign r2_in = 40'(xx_ff) + 40'(yy_ff);
   assign p2_in = 40'(pxx_ff) + 40'(pyy_ff);
   assign c_in  = 41'(xpy_ff) - 41'(ypx_ff);

   always_comb begin
      a_in        = '0;
      a_in.pos_x  = x1_ff;
      a_in.pos_y  = y1_ff;
      a_in.pos_z  = z1_ff;
      a_in.neg_q  = negq1_ff;
      a_in.pt0    = p2_in == '0;
      a_in.r0     = r2_in == '0;
      a_in.c_neg  = c_in[40];
      a_in.c_mag  = c_in[40] ? 39'(-c_in) : 39'(c_in);
      a_in.py_neg = py1_ff[19];
      a_in.py_mag = py1_ff[19] ? 20'(-py1_ff) : 20'(py1_ff);
      a_in.pz_neg = pz1_ff[19];
      a_in.pz_mag = pz1_ff[19] ? 20'(-pz1_ff) : 20'(pz1_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff <= r2_in;
         p2_ff <= p2_in;
         da_ff[0] <= a_in;
         for (int i = 1; i <= SQRT_STEPS; i++) begin
            da_ff[i] <= da_ff[i-1];
         end
      end
   end

   // Radius and pt with ten extra fraction bits
   tr2h_sqrt u_sqrt_r (
      .clock    (clock),
      .en       (en),
      .radicand ({r2_ff, 20'h00000}),
      .root_out (rf)
   );

   tr2h_sqrt u_sqrt_p (
      .clock    (clock),
      .en       (en),
      .radicand ({p2_ff, 20'h00000}),
      .root_out (pf)
   );

   // Frame angle, started late so it lands with the roots
   tr2h_cordic u_cordic (
      .clock (clock),
      .en    (en),
      .pos_x (da_ff[CORDIC_TAP].pos_x),
      .pos_y (da_ff[CORDIC_TAP].pos_y),
      .angle (angle)
   );

   // Build dividends and divisors
   assign a_end = da_ff[SQRT_STEPS];

   always_comb begin
      b_in         = '0;
      b_in.pos_z   = a_end.pos_z;
      b_in.radius  = rf[SQRT_STEPS-1:10];
      b_in.angle   = angle;
      b_in.neg_q   = a_end.neg_q;
      b_in.pt0     = a_end.pt0;
      b_in.sin_neg = a_end.r0 ? a_end.py_neg : a_end.c_neg;
      b_in.pz_neg  = a_end.pz_neg;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dsin_ff  <= a_end.r0 ? DEN_W'(pf) : DEN_W'(rf) * DEN_W'(pf);
         pf_ff    <= DEN_W'(pf);
         nsin_ff  <= a_end.r0 ? NUM_W'(a_end.py_mag) << 25 : NUM_W'(a_end.c_mag) << 35;
         ndip_ff  <= NUM_W'(a_end.pz_mag) << 26;
         db_ff[0] <= b_in;
         for (int i = 1; i <= DIV_LAT; i++) begin
            db_ff[i] <= db_ff[i-1];
         end
      end
   end

   tr2h_div u_div_sin (
      .clock (clock),
      .en    (en),
      .num   (nsin_ff),
      .den   (dsin_ff),
      .quot  (q_sin),
      .ovf   (o_sin)
   );

   tr2h_div u_div_dip (
      .clock (clock),
      .en    (en),
      .num   (ndip_ff),
      .den   (pf_ff),
      .quot  (q_dip),
      .ovf   (o_dip)
   );

   tr2h_div u_div_inv (
      .clock (clock),
      .en    (en),
      .num   (NUM_W'(1) << 38),
      .den   (pf_ff),
      .quot  (q_inv),
      .ovf   (o_inv)
   );

   // Clamp, sign and pack the result; zero pt forces zeros
   assign b_end  = db_ff[DIV_LAT];
   assign sin_in = b_end.pt0 ? '0 : sat_signed(q_sin, o_sin, b_end.sin_neg, CAP_Q15);
   assign dip_in = b_end.pt0 ? '0 : sat_signed(q_dip, o_dip, b_end.pz_neg, CAP_Q16);
   assign inv_in = b_end.pt0 ? '0 : sat_signed(q_inv, o_inv, b_end.neg_q, CAP_Q16);

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= {inv_in, dip_in, sin_in[15:0], b_end.pos_z, b_end.angle,
                     b_end.radius};
         pt0_ff  <= b_end.pt0;
      end
   end

   assign rsp_tvalid   = v_ff[DEPTH-1];
   assign rsp_tdata    = data_ff;
   assign rsp_tuser[0] = pt0_ff;

endmodule

@@ rtl/tr2h_checker.sv @@
// Port checks of the track point converter and their binding.
`include "track_ref_to_helix_params_macros.svh"

module tr2h_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [119:0] req_tdata,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // No result comes out right after reset
   `TR2H_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

   // A held result stays put
   `TR2H_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // A held result blocks new requests
   `TR2H_ASSERT_SAME(a_backpressure, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

   // Zero pt leaves sine, dip and inverse pt at zero
   `TR2H_ASSERT_SAME(a_pt_zero, clock, reset, rsp_tvalid && rsp_tuser[0],
                     rsp_tdata[119:56] == 64'h0)

endmodule

bind track_ref_to_helix_params tr2h_checker u_tr2h_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/testbench.sv @@
// Stream testbench for the track point to helix parameter converter.
module testbench
   import tr2h_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [19:0] pos_x, pos_y, pos_z, mom_x, mom_y, mom_z;
      logic               neg_q;
      logic               drain;   // wait for all results before sending
   } point_type;

   typedef struct packed {
      logic [19:0] radius;
      logic [15:0] angle;
      logic [19:0] loc_z;
      logic [15:0] sine;
      logic [23:0] dip;
      logic [23:0] inv_pt;
      logic        pt0;
   } helix_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;  // pos_x, pos_y, pos_z, mom_x, mom_y, mom_z
   logic [0:0]   req_tuser = '0;  // negative_charge
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [119:0] rsp_tdata;       // radius_xy, frame_angle, local_z, sine_phi,
                                  // dip_tangent, inv_pt_signed
   logic [0:0]   rsp_tuser;       // pt_zero

   point_type pending_points[$];
   helix_type expected_helix[$];
   point_type cur_point;
   int     mismatches = 0;
   int     gap_left = 0;
   int     burst_left = 4;
   int     stall_mode = 0;
   int     cycle_cnt = 0;

   track_ref_to_helix_params dut (.*);

   always #10 clock = ~clock;

   // floor of integer square root
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // signed quotient mag*2^shift/den, saturated, in a field of w bits
   function automatic logic [23:0] scaled_quotient(logic neg, longint unsigned mag,
                                                   int shift, longint unsigned den, int w);
      longint unsigned cap, rem, q, bitv;
      longint unsigned mask;
      cap = neg ? (64'd1 << (w - 1)) : (64'd1 << (w - 1)) - 1;
      mask = (64'd1 << w) - 1;
      rem = 0;
      q = 0;
      if (den == 0) begin
         q = cap;
      end else begin
         for (int p = 63 + shift; p >= 0; p--) begin
            bitv = (p >= shift) ? ((mag >> (p - shift)) & 1) : 0;
            rem = (rem << 1) | bitv;
            q = q << 1;
            if (rem >= den) begin
               rem = rem - den;
               q = q | 1;
            end
            if (q > cap) begin
               q = cap;
               break;
            end
         end
      end
      q = neg ? (64'd0 - q) : q;
      return 24'(q & mask);
   endfunction

   // CORDIC vectoring angle, rounded to 16 bits
   function automatic logic [15:0] cordic_angle(longint x, longint y);
      logic [31:0] z;
      longint xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 16'd0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h80000000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_TAB[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_TAB[i];
         end
      end
      z = z + 32'h8000;
      return z[31:16];
   endfunction

   function automatic helix_type predict_helix(point_type pt);
      helix_type h;
      longint x, y, px, py, pz, c;
      longint unsigned r2, p2, pf, rf;
      x = pt.pos_x; y = pt.pos_y;
      px = pt.mom_x; py = pt.mom_y; pz = pt.mom_z;
      r2 = x * x + y * y;
      p2 = px * px + py * py;
      h.radius = 20'(int_sqrt(r2));
      h.angle = cordic_angle(x, y);
      h.loc_z = pt.pos_z;
      h.sine = 0; h.dip = 0; h.inv_pt = 0; h.pt0 = 1;
      if (p2 != 0) begin
         pf = int_sqrt(p2 << 20);
         if (r2 == 0) begin
            h.sine = 16'(scaled_quotient(py < 0, py < 0 ? -py : py, 25, pf, 16));
         end else begin
            rf = int_sqrt(r2 << 20);
            c = x * py - y * px;
            h.sine = 16'(scaled_quotient(c < 0, c < 0 ? -c : c, 35, rf * pf, 16));
         end
         h.dip = scaled_quotient(pz < 0, pz < 0 ? -pz : pz, 26, pf, 24);
         h.inv_pt = scaled_quotient(pt.neg_q, 1, 38, pf, 24);
         h.pt0 = 0;
      end
      return h;
   endfunction

   function automatic point_type make_point(int x, int y, int z, int px, int py, int pz,
                                            bit nq);
      point_type p;
      p.pos_x = x; p.pos_y = y; p.pos_z = z;
      p.mom_x = px; p.mom_y = py; p.mom_z = pz;
      p.neg_q = nq; p.drain = 0;
      return p;
   endfunction

   function automatic logic signed [19:0] rand_field(int kind);
      case (kind)
         0: return 20'($urandom);
         1: return 20'($signed($urandom_range(0, 64)) - 32);
         2: return 20'($signed($urandom_range(0, 8192)) - 4096);
         default: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
      endcase
   endfunction

   // Drive requests in bursts; record the expected result on each accept.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_helix.push_back(predict_helix(cur_point));
         if (req_tvalid && !req_tready) begin
            // hold the current request
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 0;
         end else if (pending_points.size() > 0 &&
                      !(pending_points[0].drain && expected_helix.size() > 0)) begin
            cur_point = pending_points.pop_front();
            req_tvalid <= 1;
            req_tdata <= {cur_point.mom_z, cur_point.mom_y, cur_point.mom_x,
                          cur_point.pos_z, cur_point.pos_y, cur_point.pos_x};
            req_tuser <= cur_point.neg_q;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 8);
               gap_left = $urandom_range(0, 5);
            end
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // Stall the result side on a pattern that is re-chosen at random from four modes.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= (cycle_cnt % 7) != 0;
         default: rsp_tready <= $urandom_range(0, 9) == 0;
      endcase
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      helix_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.radius = rsp_tdata[19:0];
         got.angle = rsp_tdata[35:20];
         got.loc_z = rsp_tdata[55:36];
         got.sine = rsp_tdata[71:56];
         got.dip = rsp_tdata[95:72];
         got.inv_pt = rsp_tdata[119:96];
         got.pt0 = rsp_tuser[0];
         if (expected_helix.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h/%b", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_helix.pop_front();
            if (want != got) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("exp r=%h a=%h z=%h s=%h d=%h i=%h p=%b got r=%h a=%h z=%h s=%h d=%h i=%h p=%b",
                           want.radius, want.angle, want.loc_z, want.sine, want.dip,
                           want.inv_pt, want.pt0, got.radius, got.angle, got.loc_z,
                           got.sine, got.dip, got.inv_pt, got.pt0);
            end
         end
      end
   end

   initial begin
      point_type p;
      int k;
      // directed: extremes, axis points, angle of pi, zero pt, saturation
      pending_points.push_back(make_point(0, 0, 0, 0, 0, 0, 0));
      pending_points.push_back(make_point(0, 0, 5, 100, -300, 7, 1));
      pending_points.push_back(make_point(0, 0, -5, 0, -4096, 9, 0));
      pending_points.push_back(make_point(-100, 0, 1, 200, 50, 3, 0));
      pending_points.push_back(make_point(-524288, 0, 1, 1, 0, 3, 1));
      pending_points.push_back(make_point(524287, 524287, 524287, 524287, 524287, 524287, 0));
      pending_points.push_back(make_point(-524288, -524288, -524288, -524288, -524288,
                                          -524288, 1));
      pending_points.push_back(make_point(524287, -524288, 0, -524288, 524287, 0, 0));
      pending_points.push_back(make_point(64, 64, 0, 1, 0, 524287, 0));
      pending_points.push_back(make_point(64, -64, 0, 1, 0, -524288, 1));
      pending_points.push_back(make_point(1, 0, 0, 0, 1, 1, 1));
      pending_points.push_back(make_point(1, 0, 0, 0, -1, -1, 0));
      pending_points.push_back(make_point(5, 7, 3, 0, 0, 100, 1));
      pending_points.push_back(make_point(0, 1, 0, -1, 0, 0, 0));
      pending_points.push_back(make_point(0, -1, 0, 4096, 4096, 4096, 1));
      pending_points.push_back(make_point(-1, -1, -1, -1, -1, -1, 0));
      pending_points.push_back(make_point(1000, 0, 0, 0, 4096, 0, 0));
      pending_points.push_back(make_point(1000, 0, 0, 0, -4096, 0, 1));
      // random points with mixed magnitudes
      for (k = 0; k < 1450; k++) begin
         p.pos_x = rand_field($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 0);
         p.pos_y = rand_field($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 0);
         p.pos_z = rand_field($urandom_range(0, 3));
         p.mom_x = rand_field($urandom_range(0, 3));
         p.mom_y = rand_field($urandom_range(0, 3));
         p.mom_z = rand_field($urandom_range(0, 3));
         if ($urandom_range(0, 19) == 0) begin
            p.mom_x = 0;
            p.mom_y = 0;
         end
         if ($urandom_range(0, 19) == 0) begin
            p.pos_x = 0;
            p.pos_y = 0;
         end
         p.neg_q = $urandom_range(0, 1);
         p.drain = (k == 700);
         pending_points.push_back(p);
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      wait (pending_points.size() == 0);
      @(posedge clock);
      while (req_tvalid) @(posedge clock);
      while (expected_helix.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_helix.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Overall timeout
   initial begin
      #4ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
